[rtl/sus_pkg.sv]
`timescale 1ns / 1ps
package sus_pkg;

	localparam int SCENES      = 200;
	localparam int SCAN_WINDOW = 32;
	localparam int CHUNKS      = 16;
	localparam int CHUNK_BYTES = 10;

	localparam int SLOT_W    = $clog2(SCENES);
	localparam int ADDR_W    = 17;
	localparam int BASE_W    = 16;
	localparam int REC_BYTES = CHUNKS * CHUNK_BYTES;
	localparam int CHUNK_W   = $clog2(CHUNKS + 1);
	localparam int SCAN_W    = $clog2(SCAN_WINDOW + 1);

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	localparam logic [1:0] AU_HOLD = 2'd0;
	localparam logic [1:0] AU_LOAD = 2'd1;
	localparam logic [1:0] AU_ADD  = 2'd2;

	typedef struct packed {
		logic status;
		logic pending;
	} scene_entry_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		scene_entry_t      wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} store_req_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [BASE_W-1:0]  base;
		logic [SLOT_W:0]    rec;
		logic [CHUNK_W-1:0] chunk;
	} au_req_t;

endpackage

[rtl/sus_store.sv]
`timescale 1ns / 1ps
module sus_store (
	input  logic                   clk,
	input  sus_pkg::store_req_t    req,
	output sus_pkg::scene_entry_t  rdata
);
	import sus_pkg::*;

	scene_entry_t mem_q [SCENES];
	scene_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/sus_addr_unit.sv]
`timescale 1ns / 1ps
module sus_addr_unit (
	input  logic                        clk,
	input  sus_pkg::au_req_t            req,
	output logic [sus_pkg::ADDR_W-1:0]  acc
);
	import sus_pkg::*;

	logic [ADDR_W-1:0] acc_q;

	// load: base + record offset, add: + chunk offset (mod 2^ADDR_W)
	always_ff @(posedge clk) begin
		case (req.op)
			AU_LOAD: begin
				acc_q <= ADDR_W'(req.base) + ADDR_W'(req.rec) * ADDR_W'(REC_BYTES);
			end
			AU_ADD: begin
				acc_q <= acc_q + ADDR_W'(req.chunk) * ADDR_W'(CHUNK_BYTES);
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign acc = acc_q;

endmodule

[rtl/scene_update_scanner.sv]
`timescale 1ns / 1ps
// Scene update scanner. Each input word is a status write, a status read, a
// tick or an unused-mode word; each gives exactly one result word. Scene status
// and pending bits sit in a single-port-write, registered-read memory. A chunk
// tick passes through ST_ADDR0, ST_ADDR1, ST_ADDR_DONE and ST_EMIT; a search
// tick checks n (1..SCAN_WINDOW) slots, one memory read and one check per slot.
// After reset a clearing pass sweeps every memory slot, during which in_stall
// stays high; the base address register can be written at any time the block
// is idle. in_stall is high whenever an item is in progress; a finished result
// waits in the output register while the next word is taken.
module scene_update_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  scene_number,
	input  logic        level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        error,
	output logic        read_status,
	output logic        chunk_valid,
	output logic [16:0] chunk_address,
	output logic [3:0]  chunk_number,
	output logic [7:0]  scene_slot,
	output logic        last_chunk
);
	import sus_pkg::*;

	localparam logic [3:0] ST_CLEAR     = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_RD_WAIT   = 4'd2;
	localparam logic [3:0] ST_SCAN_RD   = 4'd3;
	localparam logic [3:0] ST_SCAN_CHK  = 4'd4;
	localparam logic [3:0] ST_ADDR0     = 4'd5;
	localparam logic [3:0] ST_ADDR1     = 4'd6;
	localparam logic [3:0] ST_ADDR_DONE = 4'd7;
	localparam logic [3:0] ST_EMIT      = 4'd8;

	logic [3:0]         state_q;
	logic [SLOT_W-1:0]  clr_q;
	logic [SLOT_W-1:0]  ptr_q;
	logic               sending_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic               lat_q;
	logic [BASE_W-1:0]  base_q;
	logic [SCAN_W-1:0]  scan_cnt_q;
	logic               out_valid_q;

	logic               res_error_q;
	logic               res_read_status_q;
	logic               res_chunk_valid_q;
	logic [ADDR_W-1:0]  res_chunk_address_q;
	logic [3:0]         res_chunk_number_q;
	logic [7:0]         res_scene_slot_q;
	logic               res_last_chunk_q;

	logic               out_error_q;
	logic               out_read_status_q;
	logic               out_chunk_valid_q;
	logic [ADDR_W-1:0]  out_chunk_address_q;
	logic [3:0]         out_chunk_number_q;
	logic [7:0]         out_scene_slot_q;
	logic               out_last_chunk_q;

	logic               accept;
	logic               num_ok;
	logic [SLOT_W-1:0]  num_slot;
	logic [SLOT_W:0]    ptr_plus;
	logic [SLOT_W-1:0]  ptr_next;
	logic [CHUNK_W-1:0] chunk_plus;
	logic               chunk_last;
	logic               emit_go;

	store_req_t         st_req;
	scene_entry_t       st_rdata;
	au_req_t            au_req;
	logic [ADDR_W-1:0]  au_acc;

	sus_store u_store (
		.clk   (clk),
		.req   (st_req),
		.rdata (st_rdata)
	);

	sus_addr_unit u_addr_unit (
		.clk (clk),
		.req (au_req),
		.acc (au_acc)
	);

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign num_ok     = (scene_number != 8'd0) && ({1'b0, scene_number} < 9'(SCENES));
	assign num_slot   = SLOT_W'(scene_number - 8'd1);
	assign ptr_plus   = {1'b0, ptr_q} + (SLOT_W+1)'(1);
	assign ptr_next   = (ptr_plus >= (SLOT_W+1)'(SCENES)) ? '0 : SLOT_W'(ptr_plus);
	assign chunk_plus = chunk_q + CHUNK_W'(1);
	assign chunk_last = (chunk_plus == CHUNK_W'(CHUNKS));
	assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		st_req = '0;
		case (state_q)
			ST_CLEAR: begin
				st_req.we    = 1'b1;
				st_req.waddr = clr_q;
			end
			ST_IDLE: begin
				if (accept && num_ok && mode == MODE_WRITE) begin
					st_req.we    = 1'b1;
					st_req.waddr = num_slot;
					st_req.wdata = '{status: level, pending: 1'b1};
				end
				if (accept && num_ok && mode == MODE_READ) begin
					st_req.re    = 1'b1;
					st_req.raddr = num_slot;
				end
			end
			ST_SCAN_RD: begin
				st_req.re    = 1'b1;
				st_req.raddr = ptr_next;
			end
			ST_SCAN_CHK: begin
				if (st_rdata.pending) begin
					st_req.we    = 1'b1;
					st_req.waddr = ptr_q;
					st_req.wdata = '{status: st_rdata.status, pending: 1'b0};
				end
			end
			ST_ADDR1: begin
				st_req.re    = 1'b1;
				st_req.raddr = ptr_q;
			end
			ST_ADDR_DONE: begin
				// record done: drop pending unless status changed meanwhile
				if (chunk_last && st_rdata.status == lat_q) begin
					st_req.we    = 1'b1;
					st_req.waddr = ptr_q;
					st_req.wdata = '{status: st_rdata.status, pending: 1'b0};
				end
			end
			default: begin
				st_req = '0;
			end
		endcase
	end

	always_comb begin
		au_req       = '0;
		au_req.base  = base_q;
		au_req.rec   = {ptr_q, lat_q};
		au_req.chunk = chunk_q;
		case (state_q)
			ST_ADDR0: au_req.op = AU_LOAD;
			ST_ADDR1: au_req.op = AU_ADD;
			default:  au_req.op = AU_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ptr_q       <= '0;
			sending_q   <= 1'b0;
			chunk_q     <= '0;
			lat_q       <= 1'b0;
			base_q      <= '0;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(SCENES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_READ: state_q <= num_ok ? ST_RD_WAIT : ST_EMIT;
							MODE_TICK: begin
								scan_cnt_q <= '0;
								state_q    <= sending_q ? ST_ADDR0 : ST_SCAN_RD;
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_RD_WAIT: begin
					state_q <= ST_EMIT;
				end
				ST_SCAN_RD: begin
					scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
					ptr_q      <= ptr_next;
					state_q    <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (st_rdata.pending) begin
						lat_q     <= st_rdata.status;
						chunk_q   <= '0;
						sending_q <= 1'b1;
						state_q   <= ST_EMIT;
					end else if (scan_cnt_q == SCAN_W'(SCAN_WINDOW)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_ADDR0: begin
					state_q <= ST_ADDR1;
				end
				ST_ADDR1: begin
					state_q <= ST_ADDR_DONE;
				end
				ST_ADDR_DONE: begin
					chunk_q <= chunk_plus;
					if (chunk_last) begin
						sending_q <= 1'b0;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_error_q         <= (mode == MODE_WRITE || mode == MODE_READ) && !num_ok;
			res_read_status_q   <= 1'b0;
			res_chunk_valid_q   <= 1'b0;
			res_chunk_address_q <= '0;
			res_chunk_number_q  <= '0;
			res_scene_slot_q    <= '0;
			res_last_chunk_q    <= 1'b0;
		end
		if (state_q == ST_RD_WAIT) begin
			res_read_status_q <= st_rdata.status;
		end
		if (state_q == ST_ADDR_DONE) begin
			res_chunk_valid_q   <= 1'b1;
			res_chunk_address_q <= au_acc;
			res_chunk_number_q  <= 4'(chunk_q);
			res_scene_slot_q    <= 8'(ptr_q);
			res_last_chunk_q    <= chunk_last;
		end
		if (emit_go) begin
			out_error_q         <= res_error_q;
			out_read_status_q   <= res_read_status_q;
			out_chunk_valid_q   <= res_chunk_valid_q;
			out_chunk_address_q <= res_chunk_address_q;
			out_chunk_number_q  <= res_chunk_number_q;
			out_scene_slot_q    <= res_scene_slot_q;
			out_last_chunk_q    <= res_last_chunk_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign error         = out_error_q;
	assign read_status   = out_read_status_q;
	assign chunk_valid   = out_chunk_valid_q;
	assign chunk_address = out_chunk_address_q;
	assign chunk_number  = out_chunk_number_q;
	assign scene_slot    = out_scene_slot_q;
	assign last_chunk    = out_last_chunk_q;

`ifndef SYNTHESIS
	a_chunk_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && chunk_valid) |-> (!error && !read_status))
		else $error("chunk word carries error or read status");

	a_last_num: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_chunk) |-> (chunk_valid && chunk_number == 4'(CHUNKS - 1)))
		else $error("last chunk flag on wrong chunk");

	a_send_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR_DONE && chunk_last) |=> !sending_q)
		else $error("sending not cleared after final chunk");
`endif

endmodule

[tb/sv/scene_update_scanner_checker.sv]
`timescale 1ns / 1ps
module scene_update_scanner_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  scene_number,
	input  logic        level,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        error,
	input  logic        read_status,
	input  logic        chunk_valid,
	input  logic [16:0] chunk_address,
	input  logic [3:0]  chunk_number,
	input  logic [7:0]  scene_slot,
	input  logic        last_chunk,
	output int          fail_count,
	output int          waiting,
	output int          chunk_words,
	output int          records_done
);
	import sus_pkg::*;

	typedef struct packed {
		logic        error;
		logic        read_status;
		logic        chunk_valid;
		logic [16:0] chunk_address;
		logic [3:0]  chunk_number;
		logic [7:0]  scene_slot;
		logic        last_chunk;
	} scan_word_t;

	bit          scene_on[SCENES];
	bit          scene_dirty[SCENES];
	int          scan_pos;
	bit          emitting;
	int          chunk_idx;
	bit          held_level;
	logic [15:0] base_addr;

	scan_word_t  expected_words[$];

	function automatic void clear_scenes();
		for (int i = 0; i < SCENES; i++) begin
			scene_on[i] = 1'b0;
			scene_dirty[i] = 1'b0;
		end
		scan_pos = 0;
		emitting = 1'b0;
		chunk_idx = 0;
		held_level = 1'b0;
		base_addr = '0;
	endfunction

	function automatic scan_word_t predict_word(logic [1:0] m, logic [7:0] num, logic lvl);
		scan_word_t r;
		int rec;
		int addr;
		int tries;
		bit found;
		r = '0;
		case (m)
			MODE_WRITE: begin
				if (num == 0 || num >= SCENES) begin
					r.error = 1'b1;
				end else begin
					scene_on[num - 1] = lvl;
					scene_dirty[num - 1] = 1'b1;
				end
			end
			MODE_READ: begin
				if (num == 0 || num >= SCENES)
					r.error = 1'b1;
				else
					r.read_status = scene_on[num - 1];
			end
			MODE_TICK: begin
				if (!emitting) begin
					found = 1'b0;
					tries = 0;
					while (!found && tries < SCAN_WINDOW) begin
						scan_pos = (scan_pos + 1 >= SCENES) ? 0 : scan_pos + 1;
						if (scene_dirty[scan_pos]) begin
							held_level = scene_on[scan_pos];
							scene_dirty[scan_pos] = 1'b0;
							chunk_idx = 0;
							emitting = 1'b1;
							found = 1'b1;
						end
						tries++;
					end
				end else begin
					rec = scan_pos * 2 + held_level;
					addr = base_addr + rec * REC_BYTES + chunk_idx * CHUNK_BYTES;
					r.chunk_valid = 1'b1;
					r.chunk_address = addr[16:0];
					r.chunk_number = chunk_idx[3:0];
					r.scene_slot = scan_pos[7:0];
					chunk_idx = (chunk_idx + 1) & 31;
					if (chunk_idx >= CHUNKS) begin
						r.last_chunk = 1'b1;
						emitting = 1'b0;
						if (held_level == scene_on[scan_pos])
							scene_dirty[scan_pos] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_word_t want;
		if (!arst_n) begin
			clear_scenes();
			expected_words.delete();
			fail_count = 0;
			chunk_words = 0;
			records_done = 0;
		end else begin
			if (cfg_wr_en)
				base_addr = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("error", want.error, error);
					check_field("read_status", want.read_status, read_status);
					check_field("chunk_valid", want.chunk_valid, chunk_valid);
					check_field("chunk_address", want.chunk_address, chunk_address);
					check_field("chunk_number", want.chunk_number, chunk_number);
					check_field("scene_slot", want.scene_slot, scene_slot);
					check_field("last_chunk", want.last_chunk, last_chunk);
					if (want.chunk_valid)
						chunk_words++;
					if (want.last_chunk)
						records_done++;
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(predict_word(mode, scene_number, level));
		end
		waiting = expected_words.size();
	end

endmodule

[tb/sv/scene_update_scanner_tb.sv]
`timescale 1ns / 1ps
module scene_update_scanner_tb;
	import sus_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_WRITE;
	logic [7:0]  scene_number = '0;
	logic        level = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        error;
	logic        read_status;
	logic        chunk_valid;
	logic [16:0] chunk_address;
	logic [3:0]  chunk_number;
	logic [7:0]  scene_slot;
	logic        last_chunk;

	int fail_count;
	int waiting;
	int chunk_words;
	int records_done;

	int gap_pct = 0;
	int stall_pct = 0;
	int tick_words = 0;
	int write_words = 0;
	int read_words = 0;
	int other_words = 0;

	scene_update_scanner u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.scene_number(scene_number),
		.level(level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.error(error),
		.read_status(read_status),
		.chunk_valid(chunk_valid),
		.chunk_address(chunk_address),
		.chunk_number(chunk_number),
		.scene_slot(scene_slot),
		.last_chunk(last_chunk)
	);

	scene_update_scanner_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.scene_number(scene_number),
		.level(level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.error(error),
		.read_status(read_status),
		.chunk_valid(chunk_valid),
		.chunk_address(chunk_address),
		.chunk_number(chunk_number),
		.scene_slot(scene_slot),
		.last_chunk(last_chunk),
		.fail_count(fail_count),
		.waiting(waiting),
		.chunk_words(chunk_words),
		.records_done(records_done)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		#5ms;
		$display("scene_update_scanner_tb: FAIL");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic put_word(logic [1:0] m, logic [7:0] num, logic lvl);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		scene_number <= num;
		level <= lvl;
		case (m)
			MODE_TICK: tick_words++;
			MODE_WRITE: write_words++;
			MODE_READ: read_words++;
			default: other_words++;
		endcase
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_base(logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_word();
		int pick;
		logic [7:0] bad_num;
		pick = $urandom_range(0, 99);
		bad_num = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(SCENES, 255));
		if (pick < 52)
			put_word(MODE_TICK, 8'($urandom), 1'($urandom));
		else if (pick < 77)
			put_word(MODE_WRITE, 8'($urandom_range(1, SCENES - 1)), 1'($urandom));
		else if (pick < 89)
			put_word(MODE_READ, 8'($urandom_range(1, SCENES - 1)), 1'($urandom));
		else if (pick < 93)
			put_word(MODE_WRITE, bad_num, 1'($urandom));
		else if (pick < 97)
			put_word(MODE_READ, bad_num, 1'($urandom));
		else
			put_word(MODE_UNUSED, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		int gap_tab[4];
		int stall_tab[4];
		logic [15:0] base_tab[4];
		gap_tab = '{0, 69, 0, 19};
		stall_tab = '{0, 0, 69, 19};
		base_tab = '{16'hFFFF, 16'($urandom), 16'($urandom), 16'h8000};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		while (in_stall)
			@(negedge clk);
		set_base(16'h0000);

		// bad scene numbers, unused mode
		put_word(MODE_WRITE, 8'd0, 1'b1);
		put_word(MODE_WRITE, 8'd200, 1'b1);
		put_word(MODE_READ, 8'd255, 1'b0);
		put_word(MODE_READ, 8'd0, 1'b1);
		put_word(MODE_UNUSED, 8'hA5, 1'b1);
		// first and last reachable scenes
		put_word(MODE_WRITE, 8'd1, 1'b1);
		put_word(MODE_WRITE, 8'd199, 1'b1);
		put_word(MODE_WRITE, 8'd2, 1'b1);
		put_word(MODE_READ, 8'd199, 1'b0);
		// search latches slot 1, then a full record with a write landing mid-record
		put_word(MODE_TICK, 8'hFF, 1'b1);
		repeat (8) put_word(MODE_TICK, 8'h00, 1'b0);
		put_word(MODE_WRITE, 8'd2, 1'b0);
		repeat (8) put_word(MODE_TICK, 8'h5A, 1'b0);
		put_word(MODE_READ, 8'd2, 1'b1);

		for (int p = 0; p < 4; p++) begin
			drain();
			set_base(base_tab[p]);
			gap_pct = gap_tab[p];
			stall_pct = stall_tab[p];
			repeat (125) random_word();
		end

		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (80) @(posedge clk);

		$display("sent %0d ticks, %0d writes, %0d reads, %0d unused-mode words over 5 phases",
			tick_words, write_words, read_words, other_words);
		$display("saw %0d chunk words, %0d complete records, %0d mismatches",
			chunk_words, records_done, fail_count);
		if (fail_count == 0)
			$display("scene_update_scanner_tb: PASS");
		else
			$display("scene_update_scanner_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/sus_pkg.sv
rtl/sus_store.sv
rtl/sus_addr_unit.sv
rtl/scene_update_scanner.sv
tb/sv/scene_update_scanner_checker.sv
tb/sv/scene_update_scanner_tb.sv
